// ===== hdl/ntctmrf_pkg.sv =====
// shared constants and types for the trimmed-mean rolling filter
package ntctmrf_pkg;

    // sample and history geometry
    localparam int ADC_BITS      = 12;
    localparam int HISTORY_DEPTH = 4;
    localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TOTAL_W       = ADC_BITS + $clog2(HISTORY_DEPTH);

    // group accumulation
    localparam int GROUP_SIZE    = 10;
    localparam int TRIM_DIV      = 8;
    localparam int TRIM_SHIFT    = $clog2(TRIM_DIV);
    localparam int CNT_W         = $clog2(GROUP_SIZE);
    localparam int SUM_W         = ADC_BITS + 4;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W      = ((ADC_BITS + 7) / 8) * 8;
    localparam int M_DATA_W      = ((2 * ADC_BITS + 7) / 8) * 8;

    // status from the group accumulator to the top level
    typedef struct packed {
        logic                last;     // the beat being offered closes the group
        logic [ADC_BITS-1:0] trimmed;  // trimmed mean if that beat is taken
    } grp_status_t;

endpackage

// ===== hdl/ntctmrf_group.sv =====
// group accumulator: running sum, max and min over ten samples, trimmed mean
module ntctmrf_group
    import ntctmrf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [ADC_BITS-1:0] sample,
    output grp_status_t         status
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ADC_BITS-1:0] max_reg, max_next;
    logic [ADC_BITS-1:0] min_reg, min_next;
    logic [SUM_W-1:0]    trim_sum;

    // fold the offered sample into the running values
    always_comb begin
        sum_next = sum_reg + SUM_W'(sample);
        max_next = (sample > max_reg) ? sample : max_reg;
        min_next = (sample < min_reg) ? sample : min_reg;
        count_next = count_reg + CNT_W'(1);
        trim_sum = sum_next - SUM_W'(max_next) - SUM_W'(min_next);
    end

    assign status.last    = (count_reg == CNT_W'(GROUP_SIZE - 1));
    assign status.trimmed = ADC_BITS'(trim_sum >> TRIM_SHIFT);

    // group state, restarted after the closing sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '1;
        end else if (step) begin
            if (status.last) begin
                count_reg <= '0;
                sum_reg   <= '0;
                max_reg   <= '0;
                min_reg   <= '1;
            end else begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                max_reg   <= max_next;
                min_reg   <= min_next;
            end
        end
    end

endmodule

// ===== hdl/ntc_trimmed_mean_rolling_filter.sv =====
// top level of the thermistor trimmed-mean rolling filter
// One 12-bit ADC sample enters per beat on the slave side; every tenth sample
// closes a group, whose one largest and one smallest values are dropped and the
// other eight averaged. That trimmed mean goes into a four-entry history ring
// (all zeros after reset) and one result beat leaves on the master side with
// the ring mean and the trimmed mean. Samples are taken at one per cycle while
// no closing sample waits: a sample passes an input register, then the
// accumulator and ring update logic, and a result lands in the output register
// as its closing sample leaves the input register. Only a closing sample waits on
// a stalled master side; the others keep flowing while a result is held.
module ntc_trimmed_mean_rolling_filter
    import ntctmrf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // sample, then zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // rolling_mean, trimmed_mean
);

    logic                in_valid_reg;
    logic [ADC_BITS-1:0] in_sample_reg;
    logic                m_valid_reg;
    logic [ADC_BITS-1:0] rolling_reg;
    logic [ADC_BITS-1:0] trimmed_reg;
    logic [ADC_BITS-1:0] ring_reg [HISTORY_DEPTH];
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                out_free;
    logic                fire;
    logic                close;
    grp_status_t         grp;

    // pipeline control
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!grp.last || out_free);
    assign close    = fire && grp.last;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[ADC_BITS-1:0];
        end
    end

    ntctmrf_group u_group (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .sample  (in_sample_reg),
        .status  (grp)
    );

    // ring total with the overwritten entry swapped for the new trimmed mean
    always_comb begin
        total_next = total_reg - TOTAL_W'(ring_reg[ptr_reg]) + TOTAL_W'(grp.trimmed);
        if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    // history ring, pointer and running total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            total_reg <= '0;
        end else if (close) begin
            ring_reg[ptr_reg] <= grp.trimmed;
            ptr_reg           <= ptr_next;
            total_reg         <= total_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (close) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (close) begin
            rolling_reg <= ADC_BITS'(total_next / HISTORY_DEPTH);
            trimmed_reg <= grp.trimmed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({trimmed_reg, rolling_reg});

endmodule

// ===== hdl/ntctmrf_checker.sv =====
// port-level checker for the trimmed-mean rolling filter, bound to the top level
module ntctmrf_checker
    import ntctmrf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result pending after reset");

    // with the output register empty, the input side never stalls
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // a ready master side always lets the input side move
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the master side is ready");

endmodule

bind ntc_trimmed_mean_rolling_filter ntctmrf_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/ntc_trimmed_mean_rolling_filter_test.sv =====
// self-checking stream testbench for the thermistor trimmed-mean rolling filter
`timescale 1ns / 1ps

module ntc_trimmed_mean_rolling_filter_test
    import ntctmrf_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_ITEMS   = 1300;
    localparam int DIR_ROWS     = 23;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 8;

    // result beat layout: rolling_mean in the low bits, trimmed_mean above
    typedef struct packed {
        logic [ADC_BITS-1:0] trimmed;
        logic [ADC_BITS-1:0] rolling;
    } mean_pair_t;

    // one directed stimulus row, with an optional hand-written result
    typedef struct packed {
        logic [S_DATA_W-1:0] word;
        logic                typed;
        mean_pair_t          want;
    } dir_row_t;

    // shapes of random sample groups
    typedef enum int {
        MODE_UNIFORM,
        MODE_CLUSTER,
        MODE_EXTREME,
        MODE_FLAT
    } group_mode_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // sample, then zero pad
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // rolling_mean, trimmed_mean

    // predictor state
    int                  acc_count;
    logic [SUM_W-1:0]    acc_sum;
    logic [ADC_BITS-1:0] acc_max;
    logic [ADC_BITS-1:0] acc_min;
    logic [ADC_BITS-1:0] hist [HISTORY_DEPTH];
    int                  hist_ptr;

    mean_pair_t          pending_means [$];
    dir_row_t            dir_tab [DIR_ROWS];
    int                  err_count   = 0;
    int                  cycle_count = 0;
    logic                steady      = 1'b0;

    ntc_trimmed_mean_rolling_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // clear the group accumulator for the next ten samples
    function automatic void open_group();
        acc_count = 0;
        acc_sum   = '0;
        acc_max   = '0;
        acc_min   = '1;
    endfunction

    // fold one sample into the group; returns 1 when it closes the group
    function automatic bit fold_sample(input logic [S_DATA_W-1:0] word,
                                       output mean_pair_t res);
        logic [ADC_BITS-1:0] s;
        logic [SUM_W-1:0]    trim_sum;
        logic [TOTAL_W-1:0]  total;
        s = word[ADC_BITS-1:0];
        res = '0;
        acc_sum = acc_sum + SUM_W'(s);
        if (s > acc_max) acc_max = s;
        if (s < acc_min) acc_min = s;
        acc_count++;
        if (acc_count < GROUP_SIZE) return 1'b0;
        // drop one largest and one smallest, average the other eight
        trim_sum    = acc_sum - SUM_W'(acc_max) - SUM_W'(acc_min);
        res.trimmed = ADC_BITS'(trim_sum / TRIM_DIV);
        hist[hist_ptr] = res.trimmed;
        hist_ptr = (hist_ptr + 1) % HISTORY_DEPTH;
        total = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) total = total + TOTAL_W'(hist[i]);
        res.rolling = ADC_BITS'(total / HISTORY_DEPTH);
        open_group();
        return 1'b1;
    endfunction

    // report or just count a failed check
    task automatic note_error(input string msg);
        if (err_count < MAX_SHOWN) $display("%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // offer one beat with a random gap ahead of it, then book its result
    task automatic send_sample(input logic [S_DATA_W-1:0] word, input logic typed,
                               input mean_pair_t want);
        mean_pair_t got;
        while (!steady && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fold_sample(word, got)) pending_means.push_back(typed ? want : got);
    endtask

    // random sample of the given group shape, pad bits set now and then
    function automatic logic [S_DATA_W-1:0] draw_sample(input group_mode_t mode,
                                                        input int center, input int spread);
        int v;
        logic [S_DATA_W-1:0] word;
        case (mode)
            MODE_UNIFORM: v = $urandom_range(0, (1 << ADC_BITS) - 1);
            MODE_CLUSTER: begin
                v = center + $urandom_range(0, 2 * spread) - spread;
                if (v < 0) v = 0;
                if (v > (1 << ADC_BITS) - 1) v = (1 << ADC_BITS) - 1;
            end
            MODE_EXTREME: v = ($urandom_range(0, 1) != 0) ? (1 << ADC_BITS) - 1 : 0;
            default:      v = center;
        endcase
        word = S_DATA_W'(v);
        if ($urandom_range(0, 3) == 0)
            word[S_DATA_W-1:ADC_BITS] = (S_DATA_W - ADC_BITS)'($urandom);
        return word;
    endfunction

    // receiver stalls at random outside the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 18);
    end

    // compare every result beat against the oldest prediction
    always @(posedge aclk) begin
        mean_pair_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_means.size() == 0) begin
                note_error($sformatf("unexpected result beat rolling=%0d trimmed=%0d",
                                     got.rolling, got.trimmed));
            end else begin
                want = pending_means.pop_front();
                if (got.rolling !== want.rolling)
                    note_error($sformatf("rolling_mean expected %0d got %0d",
                                         want.rolling, got.rolling));
                if (got.trimmed !== want.trimmed)
                    note_error($sformatf("trimmed_mean expected %0d got %0d",
                                         want.trimmed, got.trimmed));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ntc_trimmed_mean_rolling_filter_test: done, errors");
            $finish;
        end
    end

    initial begin
        group_mode_t mode;
        int          center;
        int          spread;

        open_group();
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = '0;
        hist_ptr = 0;

        // directed rows: a saturated group, a group with both extremes and
        // junk in the pad bits, then a few samples left open into random
        dir_tab = '{
            '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
            '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
            '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
            '{16'h0FFF, 1'b1, '{trimmed: 12'd4095, rolling: 12'd1023}},
            '{16'h0064, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'hF064, 1'b0, '0},
            '{16'h0FFF, 1'b0, '0}, '{16'h8064, 1'b0, '0}, '{16'h0064, 1'b0, '0},
            '{16'h1064, 1'b0, '0}, '{16'h0064, 1'b0, '0}, '{16'h7064, 1'b0, '0},
            '{16'h0064, 1'b1, '{trimmed: 12'd100, rolling: 12'd1048}},
            '{16'h0800, 1'b0, '0}, '{16'h07FF, 1'b0, '0}, '{16'hFFFF, 1'b0, '0}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_tab[r].word, dir_tab[r].typed, dir_tab[r].want);

        // hold off until every booked result has left
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);

        // random groups of mixed shape, with a stretch free of idling
        mode = MODE_UNIFORM;
        center = 0;
        spread = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady <= (n >= 500 && n < 800);
            if (acc_count == 0) begin
                mode   = group_mode_t'($urandom_range(0, 3));
                center = $urandom_range(0, (1 << ADC_BITS) - 1);
                spread = $urandom_range(0, 63);
            end
            send_sample(draw_sample(mode, center, spread), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the pipeline
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_means.size() != 0) note_error("results still outstanding at end");

        if (err_count == 0) begin
            $display("ntc_trimmed_mean_rolling_filter_test: done, clean");
        end else begin
            $display("ntc_trimmed_mean_rolling_filter_test: done, errors");
        end
        $finish;
    end

endmodule
